// ----- src/bounded_positional_list_core_defines.svh -----
`ifndef BOUNDED_POSITIONAL_LIST_CORE_DEFINES_SVH
`define BOUNDED_POSITIONAL_LIST_CORE_DEFINES_SVH

// Clocked check, masked while reset is asserted
`define BPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that must also hold while reset is asserted
`define BPL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ----- src/bpl_pkg.sv -----
`timescale 1ns / 1ps

package bpl_pkg;

  localparam int unsigned CountW = 7;
  localparam int unsigned IndexW = 6;
  localparam int unsigned DataW  = 32;

  typedef enum logic [2:0] {
    CMD_APPEND  = 3'd0,
    CMD_PREPEND = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_POPBACK = 3'd3,
    CMD_POPFRNT = 3'd4,
    CMD_REMOVE  = 3'd5,
    CMD_DISPLAY = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE   = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_BADPOS = 3'd3,
    ST_ENTRY  = 3'd4
  } status_e;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_REM  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e                op;
    logic [CountW-1:0]       pos;
    logic [CountW-1:0]       last_idx;
    logic signed [DataW-1:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic [2:0]              cmd;
    logic [IndexW-1:0]       position;
    logic signed [DataW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [DataW-1:0] item_value;
    logic [IndexW-1:0]       item_index;
    logic [CountW-1:0]       entry_count;
    logic                    last;
  } res_item_t;

endpackage

// ----- src/bounded_positional_list_core.sv -----
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of
// cells. An edit command (append, prepend, insert, pop back, pop front,
// remove) needs no stall: all cells shift at once, busy stays low and a
// new command may start in the next cycle. Its single status item appears
// on res_o with res_valid_o the cycle after start. A display of N entries
// streams one entry per cycle, head first, by rotating the row toward the
// head so the list is back in place at the end; busy is high until the
// last entry is issued. An empty display gives one item. Results are shown
// for one cycle only and cannot be stalled.

module bounded_positional_list_core
  import bpl_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      res_valid_o,
  output res_item_t res_o
);

`include "bounded_positional_list_core_defines.svh"

  localparam logic [CountW-1:0] Cap = CountW'(CAPACITY);

  logic [CountW-1:0] len_d, len_q;
  logic              disp_d, disp_q;
  logic [IndexW-1:0] cnt_d, cnt_q;
  logic              valid_d, valid_q;
  res_item_t         res_d, res_q;
  cell_ctl_t         ctl;
  logic [CountW-1:0] last_idx;

  logic signed [DataW-1:0] cell_data [CAPACITY];

  assign last_idx = len_q - CountW'(1);

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DataW-1:0] left_w, right_w;
    if (i == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_data[i+1];
    end
    bpl_cell #(.IDX(i)) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .left_i (left_w),
      .right_i(right_w),
      .head_i (cell_data[0]),
      .data_o (cell_data[i])
    );
  end

  // Command decode, cell control and result formation
  always_comb begin
    ctl      = '{op: CELL_HOLD, pos: '0, last_idx: last_idx, value: item_i.value};
    len_d    = len_q;
    disp_d   = disp_q;
    cnt_d    = cnt_q;
    valid_d  = 1'b0;
    res_d    = '{status: ST_DONE, item_value: '0, item_index: '0,
                 entry_count: len_q, last: 1'b1};
    if (disp_q) begin
      // stream head entry, rotate row
      ctl.op            = CELL_ROT;
      valid_d           = 1'b1;
      res_d.status      = ST_ENTRY;
      res_d.item_value  = cell_data[0];
      res_d.item_index  = cnt_q;
      res_d.last        = (cnt_q == last_idx[IndexW-1:0]);
      cnt_d             = cnt_q + IndexW'(1);
      if (res_d.last) begin
        disp_d = 1'b0;
      end
    end else if (start) begin
      valid_d = 1'b1;
      case (cmd_e'(item_i.cmd))
        CMD_APPEND, CMD_PREPEND, CMD_INSERT: begin
          case (cmd_e'(item_i.cmd))
            CMD_APPEND:  ctl.pos = len_q;
            CMD_PREPEND: ctl.pos = '0;
            default:     ctl.pos = {1'b0, item_i.position};
          endcase
          if (len_q >= Cap) begin
            res_d.status = ST_FULL;
          end else if (ctl.pos > len_q) begin
            res_d.status = ST_BADPOS;
          end else begin
            ctl.op = CELL_INS;
            len_d  = len_q + CountW'(1);
          end
        end
        CMD_POPBACK, CMD_POPFRNT, CMD_REMOVE: begin
          case (cmd_e'(item_i.cmd))
            CMD_POPBACK: ctl.pos = last_idx;
            CMD_POPFRNT: ctl.pos = '0;
            default:     ctl.pos = {1'b0, item_i.position};
          endcase
          if (len_q == '0) begin
            res_d.status = ST_EMPTY;
          end else if (ctl.pos >= len_q) begin
            res_d.status = ST_BADPOS;
          end else begin
            ctl.op = CELL_REM;
            len_d  = last_idx;
          end
        end
        CMD_DISPLAY: begin
          if (len_q == '0) begin
            res_d.status = ST_EMPTY;
          end else begin
            valid_d = 1'b0;
            disp_d  = 1'b1;
            cnt_d   = '0;
          end
        end
        default: begin
          res_d.status = ST_DONE;
        end
      endcase
      res_d.entry_count = len_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      disp_q  <= 1'b0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      len_q   <= len_d;
      disp_q  <= disp_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy        = disp_q;
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  // Checks
  `BPL_ASSERT_ALWAYS(a_reset_clears, !rst_ni |=> (len_q == '0 && !res_valid_o),
                     "state not cleared by reset")
  `BPL_ASSERT(a_len_bound, len_q <= Cap, "entry count above capacity")
  `BPL_ASSERT(a_disp_nonempty, disp_q |-> len_q != '0, "display on empty list")
  `BPL_ASSERT(a_disp_len_stable, disp_q |=> $stable(len_q),
              "count moved during display")
  `BPL_ASSERT(a_disp_last_ends,
              (res_valid_o && res_o.status == ST_ENTRY && res_o.last) |-> !busy,
              "busy after last entry")
  `BPL_ASSERT(a_disp_strobe, disp_q |=> res_valid_o, "display cycle without item")

endmodule

// ----- src/bpl_cell.sv -----
`timescale 1ns / 1ps

module bpl_cell
  import bpl_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic                    clk_i,
  input  cell_ctl_t               ctl_i,
  input  logic signed [DataW-1:0] left_i,
  input  logic signed [DataW-1:0] right_i,
  input  logic signed [DataW-1:0] head_i,
  output logic signed [DataW-1:0] data_o
);

  localparam logic [CountW-1:0] Idx = CountW'(IDX);

  logic signed [DataW-1:0] data_d, data_q;

  // Insert shifts toward tail, remove and rotate shift toward head
  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      CELL_INS: begin
        if (Idx > ctl_i.pos) begin
          data_d = left_i;
        end else if (Idx == ctl_i.pos) begin
          data_d = ctl_i.value;
        end
      end
      CELL_REM: begin
        if (Idx >= ctl_i.pos) begin
          data_d = right_i;
        end
      end
      CELL_ROT: begin
        if (Idx == ctl_i.last_idx) begin
          data_d = head_i;
        end else if (Idx < ctl_i.last_idx) begin
          data_d = right_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
